/* hw/rtl/fes_pkg.sv */
// shared types and constants for the flv elementary stream demux
// no dependencies
`default_nettype none
package fes_pkg;
  typedef enum logic [2:0] {
    RUN_NONE  = 3'd0,
    RUN_BYTE  = 3'd1,
    RUN_START = 3'd2,
    RUN_ADTS  = 3'd3,
    RUN_ERR   = 3'd4
  } run_kind_t;

  typedef struct packed {
    run_kind_t   kind;
    logic        sid;
    logic [7:0]  data;
    logic        us;
    logic [31:0] tm;
    logic [2:0]  status;
    logic [1:0]  prof;
    logic [3:0]  rate;
    logic [2:0]  chan;
    logic [12:0] flen;
  } run_t;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [4:0] PH_SIG = 5'd0, PH_HDR = 5'd1, PH_PREFIX = 5'd2,
    PH_TAGHDR = 5'd3, PH_SKIP = 5'd4, PH_VFLAGS = 5'd5, PH_VPKT = 5'd6,
    PH_VCT = 5'd7, PH_CHEAD = 5'd8, PH_CNSPS = 5'd9, PH_SLEN = 5'd10,
    PH_SDATA = 5'd11, PH_CNPPS = 5'd12, PH_PLEN = 5'd13, PH_PDATA = 5'd14,
    PH_NLEN = 5'd15, PH_NDATA = 5'd16, PH_AFLAGS = 5'd17, PH_APKT = 5'd18,
    PH_ARAW = 5'd19, PH_ASC0 = 5'd20, PH_ASC1 = 5'd21;

  localparam logic [1:0] KIND_SCRIPT = 2'd0, KIND_VIDEO = 2'd1, KIND_AUDIO = 2'd2;
  localparam logic [2:0] ERR_SIG = 3'd1, ERR_VID = 3'd2, ERR_AUD = 3'd3, ERR_TAG = 3'd4;
endpackage
`default_nettype wire

/* hw/rtl/flv_to_elementary_stream.sv */
// FLV demux to H.264 Annex B and AAC ADTS: accepts one file byte per cycle
// while the run queue has room; a byte gives at most one run, which the
// back end drains at one word per cycle unless out_stall (start codes 4,
// ADTS headers 7 words), so sustained rate is one byte per cycle except
// in header drains or stalls. Errors are sticky, one status word per byte.
// depends on fes_pkg, fes_parser, fes_queue, fes_emitter
`default_nettype none
module flv_to_elementary_stream import fes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_stream_id,
  output logic [7:0]       out_byte,
  output logic             out_unit_start,
  output logic [31:0]      out_unit_time,
  output logic [2:0]       out_status,
  output logic             out_last_of_run
);
  logic push, full, pop, empty;
  run_t din, dout;

  fes_parser u_parser (.clk, .rst_n, .in_valid, .in_stall, .in_byte,
    .q_push(push), .q_run(din), .q_full(full));
  fes_queue u_queue (.clk, .rst_n, .push, .din, .full, .pop, .dout, .empty);
  fes_emitter u_emit (.clk, .rst_n, .q_run(dout), .q_empty(empty), .q_pop(pop),
    .out_valid, .out_stall, .out_stream_id, .out_byte, .out_unit_start,
    .out_unit_time, .out_status, .out_last_of_run);
endmodule
`default_nettype wire

/* hw/rtl/fes_parser.sv */
// front end: walks flv bytes, classifying each into at most one run
// depends on fes_pkg
`default_nettype none
module fes_parser import fes_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            q_push,
  output run_t            q_run,
  input  wire logic       q_full
);
  logic [4:0]  ph_r, ph_nxt;
  logic [23:0] fc_r, fc_nxt;
  logic [23:0] tsz_r, tsz_nxt;
  logic [31:0] tt_r, tt_nxt;
  logic [2:0]  nls_r, nls_nxt;
  logic [31:0] nrem_r, nrem_nxt;
  logic [7:0]  psc_r, psc_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [3:0]  rate_r, rate_nxt;
  logic [2:0]  chan_r, chan_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [23:0] bl_r, bl_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        fu_r, fu_nxt;
  logic        acc;
  logic [7:0]  b;
  logic [23:0] bl_dec;
  logic [31:0] nlen;
  logic [15:0] plen;
  logic [4:0]  obj;
  logic [3:0]  rt;
  logic [12:0] fl;

  assign b = in_byte;
  assign in_stall = q_full;
  assign acc = in_valid && !q_full;
  assign bl_dec = bl_r - 24'd1;
  assign nlen = {nrem_r[23:0], b};
  assign plen = {nrem_r[7:0], b};
  assign obj = held_r[7:3];
  assign rt = {held_r[2:0], b[7]};
  assign fl = bl_dec[12:0] + 13'd7;

  always_comb begin
    ph_nxt = ph_r; fc_nxt = fc_r; tsz_nxt = tsz_r; tt_nxt = tt_r;
    nls_nxt = nls_r; nrem_nxt = nrem_r; psc_nxt = psc_r; prof_nxt = prof_r;
    rate_nxt = rate_r; chan_nxt = chan_r; err_nxt = err_r; bl_nxt = bl_r;
    kind_nxt = kind_r; held_nxt = held_r; fu_nxt = fu_r;
    q_run = '0;
    q_run.kind = RUN_NONE;
    q_run.tm = tt_r;
    q_run.data = b;
    if (err_r == 3'd0) begin
      unique case (ph_r)
        PH_SIG: begin
          if (b != (fc_r == 24'd0 ? 8'h46 : fc_r == 24'd1 ? 8'h4C : 8'h56)) begin
            err_nxt = ERR_SIG;
          end else if (fc_r >= 24'd2) begin
            fc_nxt = '0; ph_nxt = PH_HDR;
          end else fc_nxt = fc_r + 24'd1;
        end
        PH_HDR: begin
          if (fc_r >= 24'd5) begin fc_nxt = '0; ph_nxt = PH_PREFIX; end
          else fc_nxt = fc_r + 24'd1;
        end
        PH_PREFIX: begin
          if (fc_r >= 24'd4) begin
            fc_nxt = '0;
            if (b == 8'd8) begin kind_nxt = KIND_AUDIO; ph_nxt = PH_TAGHDR; end
            else if (b == 8'd9) begin kind_nxt = KIND_VIDEO; ph_nxt = PH_TAGHDR; end
            else if (b == 8'd18) begin kind_nxt = KIND_SCRIPT; ph_nxt = PH_TAGHDR; end
            else err_nxt = ERR_TAG;
          end else fc_nxt = fc_r + 24'd1;
        end
        PH_TAGHDR: begin
          if (fc_r < 24'd3) tsz_nxt = {tsz_r[15:0], b};
          else if (fc_r == 24'd3) tt_nxt = {24'd0, b};
          else if (fc_r < 24'd6) tt_nxt = {8'd0, tt_r[15:0], b};
          else if (fc_r == 24'd6) tt_nxt = {b, tt_r[23:0]};
          fc_nxt = fc_r + 24'd1;
          if (fc_r >= 24'd9) begin
            fc_nxt = '0;
            bl_nxt = tsz_r;
            if (tsz_r == 24'd0) ph_nxt = PH_PREFIX;
            else if (kind_r == KIND_VIDEO) ph_nxt = PH_VFLAGS;
            else if (kind_r == KIND_AUDIO) ph_nxt = PH_AFLAGS;
            else ph_nxt = PH_SKIP;
          end
        end
        default: begin
          bl_nxt = bl_dec;
          priority case (ph_r)
            PH_VFLAGS: begin
              if (b[3:0] != 4'd7) err_nxt = ERR_VID;
              else ph_nxt = PH_VPKT;
            end
            PH_VPKT: begin held_nxt = b; fc_nxt = '0; ph_nxt = PH_VCT; end
            PH_VCT: begin
              fc_nxt = fc_r + 24'd1;
              if (fc_r == 24'd2) begin
                fc_nxt = '0; nrem_nxt = '0;
                if (held_r == 8'd0) ph_nxt = PH_CHEAD;
                else if (held_r == 8'd1 && nls_r != 3'd0) begin
                  fu_nxt = 1'b1; ph_nxt = PH_NLEN;
                end else ph_nxt = PH_SKIP;
              end
            end
            PH_CHEAD: begin
              if (fc_r == 24'd4) nls_nxt = {1'b0, b[1:0]} + 3'd1;
              fc_nxt = fc_r + 24'd1;
              if (fc_r == 24'd4) ph_nxt = PH_CNSPS;
            end
            PH_CNSPS: begin
              psc_nxt = {3'd0, b[4:0]}; fc_nxt = '0; nrem_nxt = '0;
              ph_nxt = (b[4:0] == 5'd0) ? PH_CNPPS : PH_SLEN;
            end
            PH_SLEN, PH_PLEN: begin
              nrem_nxt = {16'd0, plen};
              fc_nxt = fc_r + 24'd1;
              if (fc_r == 24'd1) begin
                q_run.kind = RUN_START;
                q_run.us = (ph_r == PH_SLEN);
                if (plen == 16'd0) begin
                  psc_nxt = psc_r - 8'd1; fc_nxt = '0; nrem_nxt = '0;
                  if (ph_r == PH_SLEN) ph_nxt = (psc_r == 8'd1) ? PH_CNPPS : PH_SLEN;
                  else ph_nxt = (psc_r == 8'd1) ? PH_SKIP : PH_PLEN;
                end else ph_nxt = (ph_r == PH_SLEN) ? PH_SDATA : PH_PDATA;
              end
            end
            PH_SDATA, PH_PDATA: begin
              q_run.kind = RUN_BYTE;
              nrem_nxt = nrem_r - 32'd1;
              if (nrem_r == 32'd1) begin
                psc_nxt = psc_r - 8'd1; fc_nxt = '0; nrem_nxt = '0;
                if (ph_r == PH_SDATA) ph_nxt = (psc_r == 8'd1) ? PH_CNPPS : PH_SLEN;
                else ph_nxt = (psc_r == 8'd1) ? PH_SKIP : PH_PLEN;
              end
            end
            PH_CNPPS: begin
              psc_nxt = b; fc_nxt = '0; nrem_nxt = '0;
              ph_nxt = (b == 8'd0) ? PH_SKIP : PH_PLEN;
            end
            PH_NLEN: begin
              nrem_nxt = nlen;
              fc_nxt = fc_r + 24'd1;
              if (fc_r + 24'd1 >= {21'd0, nls_r}) begin
                fc_nxt = '0;
                if (nlen > {8'd0, bl_dec}) ph_nxt = PH_SKIP;
                else begin
                  q_run.kind = RUN_START;
                  q_run.us = fu_r;
                  fu_nxt = 1'b0;
                  ph_nxt = (nlen == 32'd0) ? PH_NLEN : PH_NDATA;
                end
              end
            end
            PH_NDATA: begin
              q_run.kind = RUN_BYTE;
              nrem_nxt = nrem_r - 32'd1;
              if (nrem_r == 32'd1) begin fc_nxt = '0; ph_nxt = PH_NLEN; end
            end
            PH_AFLAGS: begin
              if (b[7:4] != 4'd10) err_nxt = ERR_AUD;
              else ph_nxt = PH_APKT;
            end
            PH_APKT: begin
              if (b == 8'd1) begin
                if (bl_dec != 24'd0) begin
                  q_run.kind = RUN_ADTS; q_run.us = 1'b1; q_run.sid = 1'b1;
                end
                ph_nxt = PH_ARAW;
              end else ph_nxt = PH_ASC0;
            end
            PH_ARAW: begin q_run.kind = RUN_BYTE; q_run.sid = 1'b1; end
            PH_ASC0: begin held_nxt = b; ph_nxt = PH_ASC1; end
            PH_ASC1: begin
              if (obj != 5'd31) begin
                prof_nxt = (obj == 5'd1) ? 2'd0 : (obj == 5'd3) ? 2'd2 :
                           (obj == 5'd4) ? 2'd3 : 2'd1;
                rate_nxt = (rt > 4'd12) ? 4'd4 : rt;
                chan_nxt = b[5:3];
              end else begin
                rate_nxt = '0; chan_nxt = '0;
              end
              ph_nxt = PH_SKIP;
            end
            default: ;
          endcase
          if (bl_dec == 24'd0 && err_nxt == 3'd0) begin
            ph_nxt = PH_PREFIX; fc_nxt = '0;
          end
        end
      endcase
    end
    q_run.prof = prof_r; q_run.rate = rate_r; q_run.chan = chan_r; q_run.flen = fl;
    if (err_nxt != 3'd0) begin
      q_run = '0;
      q_run.kind = RUN_ERR;
      q_run.status = err_nxt;
    end
  end

  assign q_push = acc && (q_run.kind != RUN_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_SIG; fc_r <= '0; tsz_r <= '0; tt_r <= '0; nls_r <= '0;
      nrem_r <= '0; psc_r <= '0; prof_r <= 2'd1; rate_r <= '0; chan_r <= '0;
      err_r <= '0; bl_r <= '0; kind_r <= KIND_SCRIPT; held_r <= '0; fu_r <= 1'b0;
    end else if (acc) begin
      ph_r <= ph_nxt; fc_r <= fc_nxt; tsz_r <= tsz_nxt; tt_r <= tt_nxt;
      nls_r <= nls_nxt; nrem_r <= nrem_nxt; psc_r <= psc_nxt; prof_r <= prof_nxt;
      rate_r <= rate_nxt; chan_r <= chan_nxt; err_r <= err_nxt; bl_r <= bl_nxt;
      kind_r <= kind_nxt; held_r <= held_nxt; fu_r <= fu_nxt;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/fes_queue.sv */
// short run queue between the parser and the emitter
// depends on fes_pkg
`default_nettype none
module fes_queue import fes_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  run_t      din,
  output logic      full,
  input  wire logic pop,
  output run_t      dout,
  output logic      empty
);
  run_t mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0] cnt_r;

  assign full = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QAW'(1);
      if (pop) rp_r <= rp_r + QAW'(1);
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/fes_emitter.sv */
// back end: expands each queued run into output words
// depends on fes_pkg
`default_nettype none
module fes_emitter import fes_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  run_t             q_run,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_stream_id,
  output logic [7:0]       out_byte,
  output logic             out_unit_start,
  output logic [31:0]      out_unit_time,
  output logic [2:0]       out_status,
  output logic             out_last_of_run
);
  logic [2:0] idx_r;
  logic [2:0] len;
  logic       last;
  logic       fire;

  always_comb begin
    unique case (q_run.kind)
      RUN_START: len = 3'd3;
      RUN_ADTS:  len = 3'd6;
      default:   len = 3'd0;
    endcase
  end
  assign last = (idx_r == len);
  assign out_valid = !q_empty;
  assign fire = out_valid && !out_stall;
  assign q_pop = fire && last;
  assign out_last_of_run = last;
  assign out_stream_id = q_run.sid;
  assign out_unit_start = q_run.us && (idx_r == 3'd0);
  assign out_unit_time = q_run.tm;
  assign out_status = q_run.status;

  always_comb begin
    out_byte = q_run.data;
    unique case (q_run.kind)
      RUN_START: out_byte = (idx_r == 3'd3) ? 8'h01 : 8'h00;
      RUN_ADTS: begin
        unique case (idx_r)
          3'd0: out_byte = 8'hFF;
          3'd1: out_byte = 8'hF1;
          3'd2: out_byte = {q_run.prof, q_run.rate, 1'b0, q_run.chan[2]};
          3'd3: out_byte = {q_run.chan[1:0], 4'd0, q_run.flen[12:11]};
          3'd4: out_byte = q_run.flen[10:3];
          3'd5: out_byte = {q_run.flen[2:0], 5'h1F};
          default: out_byte = 8'hFC;
        endcase
      end
      RUN_ERR: out_byte = 8'h00;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (fire) idx_r <= last ? 3'd0 : idx_r + 3'd1;
  end
endmodule
`default_nettype wire
